@@ hdl/swpk_pkg.sv @@
// Shared constants for the sliding window peak event counter.
package swpk_pkg;

  // Depth of the timestamp queue, the widths that follow from it, and the timestamp and window widths.
  localparam int unsigned FIFO_DEPTH = 1024;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WIN_W      = 24;

  // Reset value of the window width register, in seconds.
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(60);

  // Sequencer state codes.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;

endpackage

@@ hdl/sliding_window_peak_event_count_unit.sv @@
// Sliding window peak event counter: timestamp queue, window test and peak tracking.
// Usage: event timestamps (whole seconds) enter on the input channel
// (in_valid_i, in_stall_o, event_time_i). A transfer happens on a rising edge
// with in_valid_i high and in_stall_o low. Every input transfer produces
// exactly one result on the output channel (out_valid_o, out_stall_i and the
// result fields), which transfers on an edge with out_valid_o high and
// out_stall_i low. The window width is written through the configuration
// channel (cfg_valid_i, cfg_ready_o, cfg_data_i); cfg_ready_o is always high,
// and the register should only be written while the block is idle.
// Timing: one item at a time; in_stall_o stays high until the item's result
// is in the output register. After its transfer an item is tested in S_CHECK;
// one that fits the window has its result registered from S_CHECK. Each expired
// entry is popped in S_CHECK (advance the head), then S_LOAD takes the
// registered read of the new head, except after the pop that empties the queue,
// which returns straight to the test. A result waiting in the output register
// does not block the next input transfer; the sequencer holds only when a new
// result is ready while the previous one is still stalled.
// Reset (rst_ni low, asynchronous) empties the queue, clears the peak record,
// drops any pending result and sets the window back to 60 seconds. The queue
// memory itself is not cleared; only held entries are ever loaded as the head.
module sliding_window_peak_event_count_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Event input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] event_time_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] window_count_o,
  output logic [10:0] peak_count_o,
  output logic [31:0] peak_start_o,
  output logic [31:0] peak_end_o,
  output logic        new_peak_o,
  output logic        dropped_o,
  // Window width register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned PtrW  = swpk_pkg::PTR_W;
  localparam int unsigned CntW  = swpk_pkg::CNT_W;
  localparam int unsigned TimeW = swpk_pkg::TIME_W;
  localparam int unsigned WinW  = swpk_pkg::WIN_W;

  // Timestamp queue memory.
  logic [TimeW-1:0] mem_q [swpk_pkg::FIFO_DEPTH];
  logic [TimeW-1:0] rdata_q;
  logic             mem_we;
  logic [PtrW-1:0]  rd_addr;

  // Sequencer and queue control.
  logic [1:0]       state_q, state_d;
  logic [PtrW-1:0]  head_q, head_d;
  logic [PtrW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [TimeW-1:0] head_val_q, head_val_d;
  logic [TimeW-1:0] time_q;
  logic [WinW-1:0]  win_q;

  // Peak record.
  logic [CntW-1:0]  best_cnt_q, best_cnt_d;
  logic [TimeW-1:0] best_start_q, best_start_d;
  logic [TimeW-1:0] best_end_q, best_end_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic [CntW-1:0]  res_cnt_q, res_cnt_d;
  logic             res_peak_q, res_peak_d;
  logic             res_drop_q, res_drop_d;

  logic             in_fire;
  logic             can_emit;
  logic             fits;
  logic [TimeW:0]   limit;
  logic             empty;
  logic             full;
  logic [PtrW-1:0]  head_next;
  logic [PtrW-1:0]  tail_next;
  logic [CntW-1:0]  count_inc;
  logic [CntW-1:0]  count_dec;

  assign in_stall_o  = (state_q != swpk_pkg::S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // A new result may be written when the output slot is empty or drains now.
  assign can_emit = !out_valid_q || !out_stall_i;

  // Window test at full width so the sum cannot wrap.
  assign limit = {1'b0, head_val_q} + {{(TimeW + 1 - WinW){1'b0}}, win_q};
  assign empty = (count_q == '0);
  assign full  = (count_q == CntW'(swpk_pkg::FIFO_DEPTH));
  assign fits  = empty || ({1'b0, time_q} <= limit);

  assign head_next = (head_q == PtrW'(swpk_pkg::FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == PtrW'(swpk_pkg::FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign count_inc = count_q + 1'b1;
  assign count_dec = count_q - 1'b1;
  assign rd_addr   = head_next;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    head_val_d   = head_val_q;
    best_cnt_d   = best_cnt_q;
    best_start_d = best_start_q;
    best_end_d   = best_end_q;
    out_valid_d  = out_valid_q && out_stall_i;
    res_cnt_d    = res_cnt_q;
    res_peak_d   = res_peak_q;
    res_drop_d   = res_drop_q;
    mem_we       = 1'b0;

    case (state_q)
      swpk_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = swpk_pkg::S_CHECK;
        end
      end
      swpk_pkg::S_CHECK: begin
        if (fits) begin
          if (can_emit) begin
            out_valid_d = 1'b1;
            res_peak_d  = 1'b0;
            state_d     = swpk_pkg::S_IDLE;
            if (full) begin
              res_cnt_d  = count_q;
              res_drop_d = 1'b1;
            end else begin
              mem_we     = 1'b1;
              tail_d     = tail_next;
              count_d    = count_inc;
              res_cnt_d  = count_inc;
              res_drop_d = 1'b0;
              if (empty) begin
                head_val_d = time_q;
              end
              // The just-pushed entry is the newest one of the window.
              if (count_inc > best_cnt_q) begin
                best_cnt_d   = count_inc;
                best_start_d = empty ? time_q : head_val_q;
                best_end_d   = time_q;
                res_peak_d   = 1'b1;
              end
            end
          end
        end else begin
          // Expired head: pop it and fetch the next head entry if any remain.
          head_d  = head_next;
          count_d = count_dec;
          if (count_dec != '0) begin
            state_d = swpk_pkg::S_LOAD;
          end
        end
      end
      swpk_pkg::S_LOAD: begin
        head_val_d = rdata_q;
        state_d    = swpk_pkg::S_CHECK;
      end
      default: begin
        state_d = swpk_pkg::S_IDLE;
      end
    endcase
  end

  // Queue memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= time_q;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      time_q <= event_time_i;
    end
    head_val_q <= head_val_d;
    res_cnt_q  <= res_cnt_d;
    res_peak_q <= res_peak_d;
    res_drop_q <= res_drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swpk_pkg::S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      best_cnt_q   <= '0;
      best_start_q <= '0;
      best_end_q   <= '0;
      out_valid_q  <= 1'b0;
      win_q        <= swpk_pkg::WIN_RESET;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      best_cnt_q   <= best_cnt_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        win_q <= cfg_data_i;
      end
    end
  end

  // The peak record only changes together with a new result, so the
  // registers can drive the outputs directly.
  assign out_valid_o    = out_valid_q;
  assign window_count_o = res_cnt_q;
  assign peak_count_o   = best_cnt_q;
  assign peak_start_o   = best_start_q;
  assign peak_end_o     = best_end_q;
  assign new_peak_o     = res_peak_q;
  assign dropped_o      = res_drop_q;

endmodule
